FILE: sv/wpdb_pkg.sv
// Shared types and constants of the wildcard priority driver binder.
package wpdb_pkg;

    localparam logic [2:0] OP_CLEAR   = 3'd0;
    localparam logic [2:0] OP_ADD_DEV = 3'd1;
    localparam logic [2:0] OP_ADD_DRV = 3'd2;
    localparam logic [2:0] OP_ADD_RUL = 3'd3;
    localparam logic [2:0] OP_BIND    = 3'd4;
    localparam logic [2:0] OP_UNBIND  = 3'd5;
    localparam logic [2:0] OP_SCAN    = 3'd6;
    localparam logic [2:0] OP_COLLECT = 3'd7;

    localparam logic [1:0] ST_AVAILABLE = 2'd0;
    localparam logic [1:0] ST_BOUND     = 2'd1;
    localparam logic [1:0] ST_GARBAGE   = 2'd2;
    localparam logic [1:0] ST_UNUSED    = 2'd3;

    localparam logic [1:0] RS_OK      = 2'd0;
    localparam logic [1:0] RS_REJECT  = 2'd1;
    localparam logic [1:0] RS_NOMATCH = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] key;
        logic [7:0]  prio;
        logic [3:0]  slot;
        logic        builtin;
        logic        removable;
    } t_req;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture request, do the ops other than the bind walk
        logic rd_dev;   // clear walk state ahead of the bind walk
        logic walk;     // advance bind walk by one rule or skipped driver
        logic first;    // first rule read of the walk
        logic finish;   // commit bind result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_bind;
        logic walk_done;
    } t_sts;

    function automatic logic key_match(input logic [63:0] d, input logic [63:0] r);
        logic ok;
        ok = (d[63:56] == r[63:56]);
        ok &= (r[55:40] == 16'hffff) || (r[55:40] == d[55:40]);
        ok &= (r[39:24] == 16'hffff) || (r[39:24] == d[39:24]);
        ok &= (r[23:16] == 8'hff) || (r[23:16] == d[23:16]);
        ok &= (r[15:8] == 8'hff) || (r[15:8] == d[15:8]);
        ok &= (r[7:0] == 8'hff) || (r[7:0] == d[7:0]);
        return ok;
    endfunction

endpackage

FILE: sv/wpdb_ram.sv
// Generic single-port-write, registered-read RAM.
module wpdb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: sv/wpdb_ctrl.sv
// Request sequencer of the binder.
module wpdb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_res_valid,
    input  logic           i_res_ready,
    input  wpdb_pkg::t_sts i_sts,
    output wpdb_pkg::t_cmd o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DEV  = 5'b00010,
        S_WALK = 5'b00100,
        S_FIN  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_first, n_first;

    always_comb begin
        n_state = r_state;
        n_first = r_first;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.is_bind) begin
                    o_cmd.rd_dev = 1'b1;
                    n_state = S_DEV;
                end else if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_DEV: begin
                n_first = 1'b1;
                n_state = S_WALK;
            end
            S_WALK: begin
                o_cmd.walk  = 1'b1;
                o_cmd.first = r_first;
                n_first = 1'b0;
                if (i_sts.walk_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // a bind request that finds its device passes through S_OUT twice; the first pass only starts the walk
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_OUT) && !i_sts.is_bind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_first <= n_first;
        end
    end
endmodule

FILE: sv/wpdb_dp.sv
// Tables and bind search of the binder.
module wpdb_dp #(
    parameter int MAX_DEVICES      = 16,
    parameter int MAX_DRIVERS      = 16,
    parameter int RULES_PER_DRIVER = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  wpdb_pkg::t_req i_req,
    input  wpdb_pkg::t_cmd i_cmd,
    output wpdb_pkg::t_sts o_sts,
    output logic [1:0]     o_status,
    output logic [3:0]     o_number
);
    localparam int DVW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
    localparam int DRW = (MAX_DRIVERS > 1) ? $clog2(MAX_DRIVERS) : 1;
    localparam int RPW = (RULES_PER_DRIVER > 1) ? $clog2(RULES_PER_DRIVER) : 1;
    localparam int NRULES = MAX_DRIVERS * RULES_PER_DRIVER;
    localparam int RAW = (NRULES > 1) ? $clog2(NRULES) : 1;
    localparam int DCW = $clog2(MAX_DEVICES + 1);
    localparam int RCW = $clog2(MAX_DRIVERS + 1);
    localparam int RTW = $clog2(RULES_PER_DRIVER + 1);

    wpdb_pkg::t_req   r_req;
    logic [DCW-1:0]   r_dev_total;
    logic [RCW-1:0]   r_drv_total;
    logic             r_present [MAX_DEVICES];
    logic             r_bound   [MAX_DEVICES];
    logic [7:0]       r_bdrv    [MAX_DEVICES];
    logic [7:0]       r_drefs   [MAX_DEVICES];
    logic [RTW-1:0]   r_rtot    [MAX_DRIVERS];
    logic [1:0]       r_dstat   [MAX_DRIVERS];
    logic [7:0]       r_refs    [MAX_DRIVERS];
    logic [1:0]       r_dflag   [MAX_DRIVERS];
    logic [1:0]       r_status;
    logic [3:0]       r_number;
    logic             r_is_bind;

    // walk state
    logic [DRW-1:0]   r_wi;
    logic [RPW-1:0]   r_wj;
    logic             r_rvld;       // a rule read was issued last cycle
    logic [DRW-1:0]   r_rdrv;
    logic             r_found;
    logic [DRW-1:0]   r_best;
    logic [7:0]       r_bestp;
    logic             r_issue_end;

    logic [63:0]      dev_key, rule_key;
    logic [7:0]       rule_prio;
    logic [63:0]      r_dkey;

    wire [DVW-1:0] dev_slot = DVW'(i_req.slot);
    wire [DRW-1:0] drv_slot = DRW'(i_req.slot);
    wire [DVW-1:0] req_dev  = DVW'(r_req.slot);

    wire dev_ok = (32'(r_dev_total) > 32'(i_req.slot));
    wire drv_ok = (32'(r_drv_total) > 32'(i_req.slot));
    wire rul_ok = drv_ok && (r_rtot[drv_slot] < RTW'(RULES_PER_DRIVER));

    logic            dev_we, rul_we;
    logic [RAW-1:0]  rul_waddr, rul_raddr;

    // rule walk address: skip drivers not available or ruleless
    wire drv_live = ({1'b0, r_wi} < r_drv_total) && (r_dstat[r_wi] == wpdb_pkg::ST_AVAILABLE)
                    && ({1'b0, r_wj} < r_rtot[r_wi]);
    wire last_j   = ({1'b0, r_wj} + RTW'(1) >= r_rtot[r_wi]) ||
                    (r_wj == RPW'(RULES_PER_DRIVER - 1));
    wire last_i   = ({1'b0, r_wi} + RCW'(1) >= r_drv_total) ||
                    (r_wi == DRW'(MAX_DRIVERS - 1));

    assign dev_we    = i_cmd.load && (i_req.op == wpdb_pkg::OP_ADD_DEV)
                       && (r_dev_total < DCW'(MAX_DEVICES));
    assign rul_we    = i_cmd.load && (i_req.op == wpdb_pkg::OP_ADD_RUL) && rul_ok;
    assign rul_waddr = RAW'(drv_slot * RULES_PER_DRIVER + r_rtot[drv_slot]);
    assign rul_raddr = RAW'(r_wi * RULES_PER_DRIVER + r_wj);

    wpdb_ram #(.WIDTH(64), .DEPTH(MAX_DEVICES)) u_dev_ram (
        .i_clk(i_clk), .i_we(dev_we), .i_waddr(r_dev_total[DVW-1:0]),
        .i_wdata(i_req.key), .i_raddr(req_dev), .o_rdata(dev_key));

    wpdb_ram #(.WIDTH(72), .DEPTH(NRULES)) u_rul_ram (
        .i_clk(i_clk), .i_we(rul_we), .i_waddr(rul_waddr),
        .i_wdata({i_req.prio, i_req.key}), .i_raddr(rul_raddr),
        .o_rdata({rule_prio, rule_key}));

    wire hit = r_rvld && wpdb_pkg::key_match(r_dkey, rule_key) &&
               (!r_found || rule_prio >= r_bestp);

    assign o_sts.is_bind   = r_is_bind;
    assign o_sts.walk_done = r_issue_end && !r_rvld;
    assign o_status = r_status;
    assign o_number = r_number;

    always_ff @(posedge i_clk) begin
        if (i_cmd.first) begin
            r_dkey <= dev_key;
        end
        if (i_cmd.load) begin
            r_req <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_cmd.load && i_req.op == wpdb_pkg::OP_CLEAR)) begin
            r_dev_total <= '0;
            r_drv_total <= '0;
            r_is_bind   <= 1'b0;
            r_rvld      <= 1'b0;
            r_issue_end <= 1'b0;
            r_found     <= 1'b0;
            r_status    <= wpdb_pkg::RS_OK;
            r_number    <= '0;
            for (int k = 0; k < MAX_DEVICES; k++) begin
                r_present[k] <= 1'b0;
                r_bound[k]   <= 1'b0;
                r_drefs[k]   <= '0;
                r_bdrv[k]    <= '0;
            end
            for (int k = 0; k < MAX_DRIVERS; k++) begin
                r_rtot[k]  <= '0;
                r_dstat[k] <= wpdb_pkg::ST_AVAILABLE;
                r_refs[k]  <= '0;
                r_dflag[k] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                case (i_req.op)
                    wpdb_pkg::OP_ADD_DEV: begin
                        if (r_dev_total < DCW'(MAX_DEVICES)) begin
                            r_present[r_dev_total[DVW-1:0]] <= 1'b1;
                            r_bound[r_dev_total[DVW-1:0]]   <= 1'b0;
                            r_drefs[r_dev_total[DVW-1:0]]   <= '0;
                            r_bdrv[r_dev_total[DVW-1:0]]    <= '0;
                            r_status    <= wpdb_pkg::RS_OK;
                            r_number    <= 4'(r_dev_total);
                            r_dev_total <= r_dev_total + DCW'(1);
                        end else begin
                            r_status <= wpdb_pkg::RS_REJECT;
                            r_number <= '0;
                        end
                    end
                    wpdb_pkg::OP_ADD_DRV: begin
                        if (r_drv_total < RCW'(MAX_DRIVERS)) begin
                            r_dstat[r_drv_total[DRW-1:0]] <= wpdb_pkg::ST_AVAILABLE;
                            r_refs[r_drv_total[DRW-1:0]]  <= '0;
                            r_rtot[r_drv_total[DRW-1:0]]  <= '0;
                            r_dflag[r_drv_total[DRW-1:0]] <= {i_req.removable, i_req.builtin};
                            r_status    <= wpdb_pkg::RS_OK;
                            r_number    <= 4'(r_drv_total);
                            r_drv_total <= r_drv_total + RCW'(1);
                        end else begin
                            r_status <= wpdb_pkg::RS_REJECT;
                            r_number <= '0;
                        end
                    end
                    wpdb_pkg::OP_ADD_RUL: begin
                        if (rul_ok) begin
                            r_rtot[drv_slot] <= r_rtot[drv_slot] + RTW'(1);
                            r_status <= wpdb_pkg::RS_OK;
                            r_number <= i_req.slot;
                        end else begin
                            r_status <= wpdb_pkg::RS_REJECT;
                            r_number <= '0;
                        end
                    end
                    wpdb_pkg::OP_BIND: begin
                        r_number <= '0;
                        if (dev_ok && r_present[dev_slot]) begin
                            r_is_bind <= 1'b1;
                            r_status  <= wpdb_pkg::RS_OK;
                        end else begin
                            r_status <= wpdb_pkg::RS_REJECT;
                        end
                    end
                    wpdb_pkg::OP_UNBIND: begin
                        if (dev_ok && r_bound[dev_slot] &&
                            ({1'b0, r_bdrv[dev_slot]} < 9'(r_drv_total)) &&
                            (32'(r_bdrv[dev_slot]) < MAX_DRIVERS)) begin
                            if (r_refs[r_bdrv[dev_slot][DRW-1:0]] <= 8'd1) begin
                                r_refs[r_bdrv[dev_slot][DRW-1:0]]  <= '0;
                                r_dstat[r_bdrv[dev_slot][DRW-1:0]] <= wpdb_pkg::ST_AVAILABLE;
                            end else begin
                                r_refs[r_bdrv[dev_slot][DRW-1:0]] <=
                                    r_refs[r_bdrv[dev_slot][DRW-1:0]] - 8'd1;
                            end
                            if (r_drefs[dev_slot] != 8'd0) begin
                                r_drefs[dev_slot] <= r_drefs[dev_slot] - 8'd1;
                            end
                            r_bound[dev_slot] <= 1'b0;
                            r_bdrv[dev_slot]  <= '0;
                            r_status <= wpdb_pkg::RS_OK;
                            r_number <= r_bdrv[dev_slot][3:0];
                        end else begin
                            r_status <= wpdb_pkg::RS_REJECT;
                            r_number <= '0;
                        end
                    end
                    wpdb_pkg::OP_SCAN: begin
                        r_status <= wpdb_pkg::RS_OK;
                        r_number <= '0;
                        for (int k = 0; k < MAX_DRIVERS; k++) begin
                            if ((RCW'(k) < r_drv_total) && !r_dflag[k][0] && r_dflag[k][1]
                                && r_refs[k] == 8'd0
                                && r_dstat[k] == wpdb_pkg::ST_AVAILABLE) begin
                                r_dstat[k] <= wpdb_pkg::ST_GARBAGE;
                            end
                        end
                    end
                    wpdb_pkg::OP_COLLECT: begin
                        r_status <= wpdb_pkg::RS_OK;
                        r_number <= '0;
                        for (int k = 0; k < MAX_DRIVERS; k++) begin
                            if ((RCW'(k) < r_drv_total) && r_refs[k] == 8'd0
                                && r_dstat[k] == wpdb_pkg::ST_GARBAGE) begin
                                r_dstat[k] <= wpdb_pkg::ST_UNUSED;
                            end
                        end
                    end
                    default: begin
                        r_status <= wpdb_pkg::RS_OK;
                        r_number <= '0;
                    end
                endcase
            end
            if (i_cmd.rd_dev) begin
                r_wi        <= '0;
                r_wj        <= '0;
                r_is_bind   <= 1'b0;
                r_found     <= 1'b0;
                r_rvld      <= 1'b0;
                r_issue_end <= 1'b0;
                r_bestp     <= '0;
            end
            if (i_cmd.walk) begin
                // score the rule read last cycle, issue the next read
                r_rvld <= !r_issue_end && drv_live;
                r_rdrv <= r_wi;
                if (hit) begin
                    r_found <= 1'b1;
                    r_best  <= r_rdrv;
                    r_bestp <= rule_prio;
                end
                if (!r_issue_end) begin
                    if (last_j || !drv_live) begin
                        r_wj <= '0;
                        if (last_i) begin
                            r_issue_end <= 1'b1;
                        end else begin
                            r_wi <= r_wi + DRW'(1);
                        end
                    end else begin
                        r_wj <= r_wj + RPW'(1);
                    end
                end
            end
            if (i_cmd.finish) begin
                if (r_found) begin
                    r_status <= wpdb_pkg::RS_OK;
                    r_number <= 4'(r_best);
                    r_bound[req_dev] <= 1'b1;
                    r_bdrv[req_dev]  <= 8'(r_best);
                    if (r_drefs[req_dev] != 8'hff) begin
                        r_drefs[req_dev] <= r_drefs[req_dev] + 8'd1;
                    end
                    if (r_refs[r_best] != 8'hff) begin
                        r_refs[r_best] <= r_refs[r_best] + 8'd1;
                    end
                    r_dstat[r_best] <= wpdb_pkg::ST_BOUND;
                end else begin
                    r_status <= wpdb_pkg::RS_NOMATCH;
                    r_number <= '0;
                end
            end
        end
    end
endmodule

FILE: sv/wildcard_priority_driver_binder_core.sv
// Top level of the wildcard priority driver binder.
//   channel | direction | tdata (low bit first)                          | tuser
//   s_axis  | in        | op, bus, vendor, product, class, subclass,     | -
//           |           | interface_req, priority_req, slot, builtin,   |
//           |           | removable (81 bits, padded to 88)             |
//   m_axis  | out       | status, number (6 bits, padded to 8)          | -
// Ops other than bind deliver their result in the cycle after acceptance.
// Bind reads one rule per cycle, skipping drivers that are not available or have no rules.
// One request is held at a time; s_axis_tready stays low until the result is taken.
// Reset is synchronous, active low; a clear request returns every table to reset.
module wildcard_priority_driver_binder_core #(
    parameter int MAX_DEVICES      = 16,
    parameter int MAX_DRIVERS      = 16,
    parameter int RULES_PER_DRIVER = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,   // op, bus, vendor, product, class, subclass,
                                        // interface_req, priority_req, slot, builtin, removable
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // status, number
);
    wpdb_pkg::t_req req;
    wpdb_pkg::t_cmd cmd;
    wpdb_pkg::t_sts sts;
    logic [1:0]     status;
    logic [3:0]     number;

    assign req.op        = s_axis_tdata[2:0];
    assign req.key       = {s_axis_tdata[10:3], s_axis_tdata[26:11], s_axis_tdata[42:27],
                            s_axis_tdata[50:43], s_axis_tdata[58:51], s_axis_tdata[66:59]};
    assign req.prio      = s_axis_tdata[74:67];
    assign req.slot      = s_axis_tdata[78:75];
    assign req.builtin   = s_axis_tdata[79];
    assign req.removable = s_axis_tdata[80];

    wpdb_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready),
        .i_sts(sts), .o_cmd(cmd));

    wpdb_dp #(
        .MAX_DEVICES(MAX_DEVICES), .MAX_DRIVERS(MAX_DRIVERS),
        .RULES_PER_DRIVER(RULES_PER_DRIVER)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req), .i_cmd(cmd),
        .o_sts(sts), .o_status(status), .o_number(number));

    assign m_axis_tdata = {2'b00, number, status};

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
    a_num_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && status != wpdb_pkg::RS_OK |-> number == 4'd0)
        else $error("nonzero number on failure");
    a_status_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> status != 2'd3) else $error("bad status");
endmodule
